// File: rtl/core/sbc_pkg.sv
// Shared types, constants and saturation helpers for the slewed biquad cascade.
// No dependencies; sbc_state_ram and the cascade top refer to it by scoped names.
package sbc_pkg;

  localparam int unsigned NUM_COEFS = 5;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_RATE   = 2'd1;
  localparam logic [1:0] REG_LEVEL  = 2'd2;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic [2:0] SEL_B0   = 3'd0;
  localparam logic [2:0] SEL_A2   = 3'd4;
  localparam logic [2:0] SEL_GAIN = 3'd5;

  localparam logic signed [31:0] ONE_Q26   = 32'sd67108864;
  localparam logic [16:0]        RATE_ONE  = 17'd65536;
  localparam logic [15:0]        LEVEL_MAX = 16'd32768;
  localparam logic [16:0]        RATE_RESET  = 17'd3277;
  localparam logic [15:0]        LEVEL_RESET = 16'd16384;

  localparam logic signed [31:0] LIMIT8_POS = 32'sd4194304;
  localparam logic signed [31:0] LIMIT8_NEG = -32'sd4194304;

  typedef struct packed {
    logic signed [23:0] s1;
    logic signed [23:0] s2;
  } sbc_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sd2147483647;
    lo = -42'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [23:0] clip4(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sd2097152;
    lo = -42'sd2097152;
    if (v > hi) return 24'sd2097152;
    else if (v < lo) return -24'sd2097152;
    else return v[23:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sd8388607;
    lo = -52'sd8388608;
    if (v > hi) return 24'sh7FFFFF;
    else if (v < lo) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage

// File: rtl/core/sbc_if.sv
// Handshake channels of the cascade: sample/coefficient input, result output,
// configuration writes. Valid/ready; a transfer happens when both are high.
interface sbc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [23:0] sample_in;
  logic [2:0]         section;
  logic [2:0]         coef_select;
  logic signed [31:0] coef_value;
  modport source (output valid, mode, sample_in, section, coef_select, coef_value,
                  input ready);
  modport sink (input valid, mode, sample_in, section, coef_select, coef_value,
                output ready);
endinterface

interface sbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;
  logic               recovered;
  modport source (output valid, sample_out, recovered, input ready);
  modport sink (input valid, sample_out, recovered, output ready);
endinterface

interface sbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/sbc_coef_ram.sv
// Coefficient memory: one write port, one registered read port, per-entry
// written flags so untouched entries read back as their reset value upstream.
module sbc_coef_ram #(
  parameter int unsigned DEPTH = 40,
  parameter int unsigned AW    = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata,
  output logic               rvalid
);

  logic signed [31:0] mem [DEPTH];
  logic [DEPTH-1:0]   written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid <= written[raddr];
      end
    end
  end

endmodule

// File: rtl/core/sbc_state_ram.sv
// Per-section filter state memory (s1, s2) with registered read.
// Uses sbc_pkg::sbc_state_t; a bulk clear drops every entry back to zero.
module sbc_state_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear_all,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  sbc_pkg::sbc_state_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output sbc_pkg::sbc_state_t rdata
);

  sbc_pkg::sbc_state_t mem [DEPTH];
  logic [DEPTH-1:0]    written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= written[raddr] ? mem[raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

endmodule

// File: rtl/core/slewed_biquad_cascade.sv
// channel | dir | payload                                         | transfer
// in_ch   | in  | mode, sample_in, section, coef_select, coef_value | valid && ready
// out_ch  | out | sample_out, recovered                             | valid && ready
// cfg     | in  | index, data                                       | valid && ready
//
// A coefficient write is taken in the idle state. A sample runs, per active section,
// five slew updates (read, slew, update on the shared multiplier), then six filter
// steps, then the overflow check, gain/level scaling and handoff (the scaling is
// skipped when overflow recovery clears the states), and returns to idle for the
// next transfer. rst is synchronous; coefficient and state memories read as
// reset values via written flags, so no clearing pass is needed. A result waits
// in the output register while the next item is accepted; a stalled output holds
// the engine at its final step only. Depends on sbc_pkg, sbc_if, sbc_coef_ram,
// sbc_state_ram.
module slewed_biquad_cascade #(
  parameter int unsigned SECTIONS = 8
) (
  input  logic             clk,
  input  logic             rst,
  sbc_in_if.sink           in_ch,
  sbc_out_if.source        out_ch,
  sbc_cfg_if.sink          cfg
);

  localparam int unsigned DEPTH = SECTIONS * sbc_pkg::NUM_COEFS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int unsigned CW    = $clog2(SECTIONS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_SLEW = 4'd2;
  localparam logic [3:0] S_UPD  = 4'd3;
  localparam logic [3:0] S_M0   = 4'd4;
  localparam logic [3:0] S_Y    = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_M4   = 4'd8;
  localparam logic [3:0] S_ST   = 4'd9;
  localparam logic [3:0] S_CHK  = 4'd10;
  localparam logic [3:0] S_L    = 4'd11;
  localparam logic [3:0] S_F    = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]  state;
  logic [3:0]  active_sections;
  logic [16:0] slew_rate;
  logic [15:0] output_level;
  logic signed [31:0] gain_value;

  logic [CW-1:0] n_sec;
  logic [CW-1:0] sec;
  logic [AW-1:0] addr;
  logic [2:0]    cidx;
  logic [16:0]   rate;
  logic [15:0]   lvl;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] coef [sbc_pkg::NUM_COEFS];
  logic signed [41:0] acc_a;
  logic signed [41:0] acc_b;
  logic signed [65:0] prod;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [23:0] res_out;
  logic               res_rec;
  logic               out_valid;
  logic signed [23:0] out_data;
  logic               out_rec;

  logic in_xfer;
  logic cfg_xfer;
  logic out_load;
  logic [CW-1:0] n_clamped;

  // coefficient memories
  logic               tgt_we;
  logic [AW-1:0]      tgt_waddr;
  logic signed [31:0] cur_rdata;
  logic signed [31:0] tgt_rdata;
  logic               cur_rvalid;
  logic               tgt_rvalid;
  logic               coef_re;
  logic               cur_we;
  logic signed [31:0] reset_coef;
  logic signed [31:0] cur_eff;
  logic signed [31:0] tgt_eff;
  logic signed [31:0] cur_new;

  // state memory
  logic                st_clear;
  logic                st_we;
  logic                st_re;
  sbc_pkg::sbc_state_t st_wdata;
  sbc_pkg::sbc_state_t st_rdata;

  logic signed [39:0] p_q;
  logic signed [41:0] p_ext;
  logic signed [41:0] b_sum;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg.valid && cfg.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign out_load = (state == S_DONE) && (!out_valid || out_ch.ready);

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_data;
  assign out_ch.recovered  = out_rec;

  assign n_clamped = (32'(active_sections) > SECTIONS) ? CW'(SECTIONS)
                                                       : CW'(active_sections);

  assign tgt_we = in_xfer && (in_ch.mode == sbc_pkg::MODE_COEF)
                  && (in_ch.coef_select <= sbc_pkg::SEL_A2)
                  && (32'(in_ch.section) < SECTIONS);
  assign tgt_waddr = AW'(32'(in_ch.section) * sbc_pkg::NUM_COEFS
                         + 32'(in_ch.coef_select));

  assign coef_re    = (state == S_RD);
  assign reset_coef = (cidx == sbc_pkg::SEL_B0) ? sbc_pkg::ONE_Q26 : 32'sd0;
  assign cur_eff    = cur_rvalid ? cur_rdata : reset_coef;
  assign tgt_eff    = tgt_rvalid ? tgt_rdata : reset_coef;
  assign cur_new    = 32'({cur_eff[31], cur_eff} + prod[48:16]);
  assign cur_we     = (state == S_UPD);

  assign st_re    = (state == S_RD) && (cidx == 3'd0);
  assign st_we    = (state == S_ST);
  assign st_clear = (state == S_CHK) && ((x > sbc_pkg::LIMIT8_POS)
                                         || (x < sbc_pkg::LIMIT8_NEG));

  // floored Q26 product, the same shift serves every filter coefficient multiply and the gain
  assign p_q   = prod[65:26];
  assign p_ext = 42'(p_q);
  assign b_sum = acc_b - p_ext;
  assign st_wdata.s1 = sbc_pkg::clip4(acc_a);
  assign st_wdata.s2 = sbc_pkg::clip4(b_sum);

  sbc_coef_ram #(.DEPTH(DEPTH), .AW(AW)) u_cur_ram (
    .clk    (clk),
    .rst    (rst),
    .we     (cur_we),
    .waddr  (addr),
    .wdata  (cur_new),
    .re     (coef_re),
    .raddr  (addr),
    .rdata  (cur_rdata),
    .rvalid (cur_rvalid)
  );

  sbc_coef_ram #(.DEPTH(DEPTH), .AW(AW)) u_tgt_ram (
    .clk    (clk),
    .rst    (rst),
    .we     (tgt_we),
    .waddr  (tgt_waddr),
    .wdata  (in_ch.coef_value),
    .re     (coef_re),
    .raddr  (addr),
    .rdata  (tgt_rdata),
    .rvalid (tgt_rvalid)
  );

  sbc_state_ram #(.DEPTH(SECTIONS), .AW(SW)) u_state_ram (
    .clk       (clk),
    .rst       (rst),
    .clear_all (st_clear),
    .we        (st_we),
    .waddr     (sec[SW-1:0]),
    .wdata     (st_wdata),
    .re        (st_re),
    .raddr     (sec[SW-1:0]),
    .rdata     (st_rdata)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SLEW: begin
        mul_a = {tgt_eff[31], tgt_eff} - {cur_eff[31], cur_eff};
        mul_b = 33'({1'b0, rate});
      end
      S_M0: begin
        mul_a = 33'(coef[0]);
        mul_b = 33'(x);
      end
      S_Y: begin
        mul_a = 33'(coef[1]);
        mul_b = 33'(x);
      end
      S_M3: begin
        mul_a = 33'(coef[3]);
        mul_b = 33'(y);
      end
      S_M2: begin
        mul_a = 33'(coef[2]);
        mul_b = 33'(x);
      end
      S_M4: begin
        mul_a = 33'(coef[4]);
        mul_b = 33'(y);
      end
      S_CHK: begin
        mul_a = 33'(gain_value);
        mul_b = 33'(x);
      end
      S_L: begin
        mul_a = p_q[32:0];
        mul_b = 33'({1'b0, lvl});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x <= 32'(in_ch.sample_in);
      end
      S_UPD: begin
        coef[cidx] <= cur_new;
      end
      S_Y: begin
        y <= sbc_pkg::sat32(p_ext + 42'(st_rdata.s1));
      end
      S_M3: begin
        acc_a <= p_ext + 42'(st_rdata.s2);
      end
      S_M2: begin
        acc_a <= acc_a - p_ext;
      end
      S_M4: begin
        acc_b <= p_ext;
      end
      S_ST: begin
        x <= y;
      end
      S_CHK: begin
        res_out <= '0;
        res_rec <= 1'b1;
      end
      S_F: begin
        res_out <= sbc_pkg::sat24(prod[65:14]);
        res_rec <= 1'b0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data <= res_out;
      out_rec  <= res_rec;
    end
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      active_sections <= '0;
      slew_rate       <= sbc_pkg::RATE_RESET;
      output_level    <= sbc_pkg::LEVEL_RESET;
      gain_value      <= sbc_pkg::ONE_Q26;
      out_valid       <= 1'b0;
      sec             <= '0;
      n_sec           <= '0;
      addr            <= '0;
      cidx            <= '0;
      rate            <= '0;
      lvl             <= '0;
    end else begin
      if (cfg_xfer) begin
        priority case (cfg.index)
          sbc_pkg::REG_ACTIVE: active_sections <= cfg.data[3:0];
          sbc_pkg::REG_RATE:   slew_rate       <= cfg.data;
          sbc_pkg::REG_LEVEL:  output_level    <= cfg.data[15:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.mode == sbc_pkg::MODE_COEF) begin
              if (in_ch.coef_select == sbc_pkg::SEL_GAIN) begin
                gain_value <= in_ch.coef_value;
              end
            end else begin
              n_sec <= n_clamped;
              rate  <= (slew_rate > sbc_pkg::RATE_ONE) ? sbc_pkg::RATE_ONE : slew_rate;
              lvl   <= (output_level > sbc_pkg::LEVEL_MAX) ? sbc_pkg::LEVEL_MAX
                                                           : output_level;
              sec   <= '0;
              addr  <= '0;
              cidx  <= '0;
              state <= (n_clamped == '0) ? S_CHK : S_RD;
            end
          end
        end
        S_RD:   state <= S_SLEW;
        S_SLEW: state <= S_UPD;
        S_UPD: begin
          addr <= addr + AW'(1);
          if (cidx == sbc_pkg::SEL_A2) begin
            cidx  <= '0;
            state <= S_M0;
          end else begin
            cidx  <= cidx + 3'd1;
            state <= S_RD;
          end
        end
        S_M0: state <= S_Y;
        S_Y:  state <= S_M3;
        S_M3: state <= S_M2;
        S_M2: state <= S_M4;
        S_M4: state <= S_ST;
        S_ST: begin
          // advance to the next section or finish the cascade
          if (sec == n_sec - CW'(1)) begin
            state <= S_CHK;
          end else begin
            sec   <= sec + CW'(1);
            state <= S_RD;
          end
        end
        S_CHK: state <= st_clear ? S_DONE : S_L;
        S_L:   state <= S_F;
        S_F:   state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_recover_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.recovered) |-> (out_ch.sample_out == 24'sd0))
    else $error("recovered result carries a nonzero sample");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result appeared without the final engine step");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ST) |-> (sec < n_sec))
    else $error("section counter ran past the active count");

  a_coef_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> ((cidx <= sbc_pkg::SEL_A2) && (state == S_RD || state == S_M0)))
    else $error("coefficient walk left its range");
`endif

endmodule
